// ===== hw/rtl/longest_run_set_with_rollback_assert.svh =====
// Assertion macros for the lrs_check checker file.
`ifndef LONGEST_RUN_SET_WITH_ROLLBACK_ASSERT_SVH
`define LONGEST_RUN_SET_WITH_ROLLBACK_ASSERT_SVH

// Same-cycle implication.
`define LRS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lrs_pkg.sv =====
package lrs_pkg;

   localparam int MAX_VALUE  = 4096;
   localparam int TABLE_SIZE = MAX_VALUE + 2;
   localparam int LOG_SIZE   = 4 * MAX_VALUE;
   localparam int RUN_W      = 13;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int DEPTH_W    = $clog2(LOG_SIZE + 1);
   localparam int LOG_AW     = $clog2(LOG_SIZE);
   localparam int VALUE_W    = 13;

   typedef enum logic [1:0] {
      KIND_INSERT     = 2'd0,
      KIND_CHECKPOINT = 2'd1,
      KIND_ROLLBACK   = 2'd2,
      KIND_CLEAR      = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [VALUE_W-1:0]   value;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic               sel;    // 0 left table, 1 right table
      logic [IDX_W-1:0]   index;
      logic [RUN_W-1:0]   old;
   } log_entry_type;

endpackage

// ===== hw/rtl/lrs_front.sv =====
module lrs_front
   import lrs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [1:0]     in_kind,
   input  logic [VALUE_W-1:0] in_value,
   input  logic           hold,
   input  logic           pop,
   output queue_head_type head
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item;

   always_comb begin
      item.kind  = kind_type'(in_kind);
      item.value = in_value;
   end

   assign in_ready = (count_ff != 2'd2) && !hold;
   assign push     = in_valid && in_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= item;
   end

   always_comb begin
      head.valid = (count_ff != 2'd0);
      head.item  = slot_ff[rd_ptr_ff];
   end

endmodule

// ===== hw/rtl/lrs_back.sv =====
module lrs_back
   import lrs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  queue_head_type     head,
   output logic               pop,
   output logic               clearing,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [RUN_W-1:0]   out_run,
   output logic               out_dup
);

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_CALC  = 9'b000000100,
      ST_W1    = 9'b000001000,
      ST_W2    = 9'b000010000,
      ST_W3    = 9'b000100000,
      ST_W4    = 9'b001000000,
      ST_UNDO  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [IDX_W-1:0]    v_ff, v_in;
   logic [RUN_W-1:0]    lv_ff, lv_in, rv_ff, rv_in, total_ff, total_in;
   logic [RUN_W-1:0]    best_ff, best_in, saved_best_ff, saved_best_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in, saved_depth_ff, saved_depth_in;
   logic [DEPTH_W-1:0]  target_ff, target_in, depth_dec;
   logic                pend_ff, pend_in, dup_ff, dup_in;
   logic                out_valid_ff, out_valid_in;

   logic [RUN_W-1:0]    left_mem  [TABLE_SIZE];
   logic [RUN_W-1:0]    right_mem [TABLE_SIZE];
   log_entry_type       log_mem   [LOG_SIZE];

   logic [RUN_W-1:0]    left_a_ff, left_b_ff, right_a_ff, right_b_ff;
   logic                rd_a_en, rd_b_en;
   logic [IDX_W-1:0]    left_a_addr, left_b_addr, right_a_addr, right_b_addr;
   logic                lw_en, rw_en;
   logic [IDX_W-1:0]    lw_addr, rw_addr;
   logic [RUN_W-1:0]    lw_data, rw_data;
   logic                log_we, log_re;
   log_entry_type       log_wdata, pend_entry_ff;

   logic [IDX_W-1:0]    hv;
   logic                in_range, slot_free;
   logic [RUN_W-1:0]    lv_lim, rv_lim, lv_c, rv_c;

   assign hv        = IDX_W'(head.item.value);
   assign in_range  = (head.item.value != '0) &&
                      (head.item.value <= VALUE_W'(MAX_VALUE));
   assign slot_free = !out_valid_ff || out_ready;
   assign depth_dec = depth_ff - DEPTH_W'(1);

   // Clamp the neighbor runs to the table edges.
   always_comb begin
      lv_lim = RUN_W'(v_ff - IDX_W'(1));
      rv_lim = RUN_W'(IDX_W'(MAX_VALUE) - v_ff);
      lv_c   = (left_b_ff > lv_lim) ? lv_lim : left_b_ff;
      rv_c   = (right_b_ff > rv_lim) ? rv_lim : right_b_ff;
   end

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      v_in           = v_ff;
      lv_in          = lv_ff;
      rv_in          = rv_ff;
      total_in       = total_ff;
      best_in        = best_ff;
      saved_best_in  = saved_best_ff;
      depth_in       = depth_ff;
      saved_depth_in = saved_depth_ff;
      target_in      = target_ff;
      pend_in        = 1'b0;
      dup_in         = dup_ff;
      out_valid_in   = out_valid_ff && !out_ready;
      pop            = 1'b0;
      rd_a_en        = 1'b0;
      rd_b_en        = 1'b0;
      left_a_addr    = hv;
      right_a_addr   = hv;
      left_b_addr    = hv - IDX_W'(1);
      right_b_addr   = hv + IDX_W'(1);
      lw_en          = 1'b0;
      rw_en          = 1'b0;
      lw_addr        = v_ff;
      rw_addr        = v_ff;
      lw_data        = '0;
      rw_data        = '0;
      log_we         = 1'b0;
      log_re         = 1'b0;
      log_wdata      = '{sel: 1'b0, index: v_ff, old: left_a_ff};

      // Apply a popped log entry.
      if (pend_ff) begin
         if (pend_entry_ff.sel) begin
            rw_en   = 1'b1;
            rw_addr = pend_entry_ff.index;
            rw_data = pend_entry_ff.old;
         end else begin
            lw_en   = 1'b1;
            lw_addr = pend_entry_ff.index;
            lw_data = pend_entry_ff.old;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            lw_en   = 1'b1;
            rw_en   = 1'b1;
            lw_addr = clr_cnt_ff;
            rw_addr = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == IDX_W'(TABLE_SIZE - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (head.valid && slot_free) begin
               pop    = 1'b1;
               dup_in = 1'b0;
               v_in   = hv;
               unique case (head.item.kind)
                  KIND_INSERT: begin
                     if (in_range) begin
                        rd_a_en  = 1'b1;
                        rd_b_en  = 1'b1;
                        state_in = ST_CALC;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  KIND_CHECKPOINT: begin
                     saved_depth_in = depth_ff;
                     saved_best_in  = best_ff;
                     state_in       = ST_DONE;
                  end
                  KIND_ROLLBACK: begin
                     target_in = saved_depth_ff;
                     best_in   = saved_best_ff;
                     state_in  = ST_UNDO;
                  end
                  KIND_CLEAR: begin
                     target_in      = '0;
                     best_in        = '0;
                     saved_depth_in = '0;
                     saved_best_in  = '0;
                     state_in       = ST_UNDO;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CALC: begin
            if (left_a_ff != '0) begin
               dup_in   = 1'b1;
               state_in = ST_DONE;
            end else if (depth_ff + DEPTH_W'(4) > DEPTH_W'(LOG_SIZE)) begin
               state_in = ST_DONE;
            end else begin
               lv_in        = lv_c;
               rv_in        = rv_c;
               total_in     = lv_c + rv_c + RUN_W'(1);
               rd_b_en      = 1'b1;
               left_b_addr  = v_ff + IDX_W'(rv_c);
               right_b_addr = v_ff - IDX_W'(lv_c);
               state_in     = ST_W1;
            end
         end
         ST_W1: begin
            lw_en     = 1'b1;
            lw_data   = lv_ff + RUN_W'(1);
            log_we    = 1'b1;
            log_wdata = '{sel: 1'b0, index: v_ff, old: left_a_ff};
            depth_in  = depth_ff + DEPTH_W'(1);
            state_in  = ST_W2;
         end
         ST_W2: begin
            rw_en     = 1'b1;
            rw_data   = rv_ff + RUN_W'(1);
            log_we    = 1'b1;
            log_wdata = '{sel: 1'b1, index: v_ff, old: right_a_ff};
            depth_in  = depth_ff + DEPTH_W'(1);
            if (total_ff > best_ff) best_in = total_ff;
            state_in  = ST_W3;
         end
         ST_W3: begin
            if (lv_ff != '0) begin
               rw_en     = 1'b1;
               rw_addr   = v_ff - IDX_W'(lv_ff);
               rw_data   = total_ff;
               log_we    = 1'b1;
               log_wdata = '{sel: 1'b1, index: v_ff - IDX_W'(lv_ff), old: right_b_ff};
               depth_in  = depth_ff + DEPTH_W'(1);
            end
            state_in = ST_W4;
         end
         ST_W4: begin
            if (rv_ff != '0) begin
               lw_en     = 1'b1;
               lw_addr   = v_ff + IDX_W'(rv_ff);
               lw_data   = total_ff;
               log_we    = 1'b1;
               log_wdata = '{sel: 1'b0, index: v_ff + IDX_W'(rv_ff), old: left_b_ff};
               depth_in  = depth_ff + DEPTH_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_UNDO: begin
            // Pop one entry a cycle; its write lands the cycle after.
            if (depth_ff > target_ff) begin
               log_re   = 1'b1;
               depth_in = depth_dec;
               pend_in  = 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            out_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         best_ff        <= '0;
         saved_best_ff  <= '0;
         depth_ff       <= '0;
         saved_depth_ff <= '0;
         target_ff      <= '0;
         pend_ff        <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         best_ff        <= best_in;
         saved_best_ff  <= saved_best_in;
         depth_ff       <= depth_in;
         saved_depth_ff <= saved_depth_in;
         target_ff      <= target_in;
         pend_ff        <= pend_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      lv_ff    <= lv_in;
      rv_ff    <= rv_in;
      total_ff <= total_in;
      dup_ff   <= dup_in;
   end

   always_ff @(posedge clock) begin
      if (lw_en) left_mem[lw_addr] <= lw_data;
      if (rd_a_en) left_a_ff <= left_mem[left_a_addr];
      if (rd_b_en) left_b_ff <= left_mem[left_b_addr];
   end

   always_ff @(posedge clock) begin
      if (rw_en) right_mem[rw_addr] <= rw_data;
      if (rd_a_en) right_a_ff <= right_mem[right_a_addr];
      if (rd_b_en) right_b_ff <= right_mem[right_b_addr];
   end

   always_ff @(posedge clock) begin
      if (log_we) log_mem[depth_ff[LOG_AW-1:0]] <= log_wdata;
      if (log_re) pend_entry_ff <= log_mem[depth_dec[LOG_AW-1:0]];
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign out_valid = out_valid_ff;
   assign out_run   = best_ff;
   assign out_dup   = dup_ff;

endmodule

// ===== hw/rtl/longest_run_set_with_rollback.sv =====
// Sequence: an insert passes ST_CALC, the table writes ST_W1 to ST_W4, then ST_DONE;
// a duplicate insert goes from ST_CALC to ST_DONE; checkpoint and out-of-range insert
// go straight to ST_DONE; rollback and clear pop one undo-log entry a cycle in ST_UNDO.
// Throughput: one item at a time through the back-end table sequencer; an
// insert holds it through up to four serialized table writes.
// Reset: synchronous; a clearing pass zeroes both 4098-entry run tables, req_tready low.
module longest_run_set_with_rollback
   import lrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [12:0] value, [15:13] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [12:0] longest_run, [15:13] zero
   output logic        rsp_tuser    // [0] duplicate
);

   queue_head_type     head;
   logic               pop, clearing;
   logic [RUN_W-1:0]   run;

   lrs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_kind  (req_tuser),
      .in_value (req_tdata[VALUE_W-1:0]),
      .hold     (clearing),
      .pop      (pop),
      .head     (head)
   );

   lrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .clearing  (clearing),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_run   (run),
      .out_dup   (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, run};

endmodule

// ===== hw/rtl/lrs_check.sv =====
`include "longest_run_set_with_rollback_assert.svh"

module lrs_check
   import lrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   `LRS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")
   `LRS_ASSERT_NOW(a_dup_nonempty, rsp_tvalid && rsp_tuser, rsp_tdata[12:0] != 13'd0, "duplicate reported on empty set")
   `LRS_ASSERT_NOW(a_pad_zero, rsp_tvalid, rsp_tdata[15:13] == 3'd0, "response padding not zero")
   `LRS_ASSERT_NOW(a_run_bound, rsp_tvalid, rsp_tdata[12:0] <= 13'(MAX_VALUE), "run exceeds value range")

endmodule

bind longest_run_set_with_rollback lrs_check u_lrs_check (.*);

// ===== sim/longest_run_set_with_rollback_tb.sv =====
module longest_run_set_with_rollback_tb;
   import lrs_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   class run_scoreboard;
      logic [12:0] left_len [0:MAX_VALUE+1];
      logic [12:0] right_len [0:MAX_VALUE+1];
      log_entry_type undo_q [$];
      int unsigned saved_depth;
      logic [12:0] best;
      logic [12:0] saved_best;
      logic [13:0] expected_q [$];   // {duplicate, longest_run}
      int errors;

      function void clear_tables();
         for (int i = 0; i <= MAX_VALUE + 1; i++) begin
            left_len[i] = '0;
            right_len[i] = '0;
         end
         undo_q = {};
         saved_depth = 0;
         best = '0;
         saved_best = '0;
         errors = 0;
      endfunction

      function void logged_write(logic sel, int idx, logic [12:0] val);
         log_entry_type e;
         e.sel = sel;
         e.index = IDX_W'(idx);
         e.old = sel ? right_len[idx] : left_len[idx];
         undo_q.push_back(e);
         if (sel) right_len[idx] = val;
         else left_len[idx] = val;
      endfunction

      function void unwind(int unsigned depth);
         log_entry_type e;
         while (undo_q.size() > depth) begin
            e = undo_q.pop_back();
            if (e.sel) right_len[e.index] = e.old;
            else left_len[e.index] = e.old;
         end
      endfunction

      function void note_item(kind_type kind, int v);
         int lv, rv, total;
         logic dup;
         dup = 1'b0;
         case (kind)
            KIND_INSERT: begin
               if (v >= 1 && v <= MAX_VALUE) begin
                  if (left_len[v] != 0) begin
                     dup = 1'b1;
                  end else begin
                     lv = left_len[v-1];
                     rv = right_len[v+1];
                     if (lv > v - 1) lv = v - 1;
                     if (rv > MAX_VALUE - v) rv = MAX_VALUE - v;
                     total = lv + rv + 1;
                     logged_write(1'b0, v, 13'(lv + 1));
                     logged_write(1'b1, v, 13'(rv + 1));
                     if (total > best) best = 13'(total);
                     if (lv != 0) logged_write(1'b1, v - lv, 13'(total));
                     if (rv != 0) logged_write(1'b0, v + rv, 13'(total));
                  end
               end
            end
            KIND_CHECKPOINT: begin
               saved_depth = undo_q.size();
               saved_best = best;
            end
            KIND_ROLLBACK: begin
               unwind(saved_depth);
               best = saved_best;
            end
            default: begin
               unwind(0);
               best = '0;
               saved_depth = 0;
               saved_best = '0;
            end
         endcase
         expected_q.push_back({dup, best});
      endfunction

      function void check_result(logic [12:0] run_len, logic dup);
         logic [13:0] exp_v;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result run=%0d dup=%0b", $time, run_len, dup);
            errors++;
            return;
         end
         exp_v = expected_q.pop_front();
         if (exp_v[12:0] !== run_len) begin
            $display("%0t: longest_run expected %0d actual %0d", $time, exp_v[12:0],
                     run_len);
            errors++;
         end
         if (exp_v[13] !== dup) begin
            $display("%0t: duplicate expected %0b actual %0b", $time, exp_v[13], dup);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   run_scoreboard board;
   int unsigned cycle_count;
   bit hold_rsp;

   longest_run_set_with_rollback i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Present one item and hold it until the transfer.
   task automatic send_item(kind_type kind, logic [12:0] v, bit with_gaps);
      int gap;
      gap = with_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {3'b000, v};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(kind, v);
   endtask

   task automatic send_random(int count);
      int r;
      kind_type k;
      logic [12:0] v;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            k = KIND_INSERT;
            // Mostly a small window so runs grow and merge; some wide or odd values.
            r = $urandom_range(0, 99);
            if (r < 75) v = 13'($urandom_range(1, 64));
            else if (r < 95) v = 13'($urandom_range(1, MAX_VALUE));
            else v = 13'($urandom);
         end else if (r < 82) begin
            k = KIND_CHECKPOINT;
            v = 13'($urandom);
         end else if (r < 96) begin
            k = KIND_ROLLBACK;
            v = 13'($urandom);
         end else begin
            k = KIND_CLEAR;
            v = 13'($urandom);
         end
         send_item(k, v, 1'b1);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata[12:0], rsp_tuser);
         if (hold_rsp) rsp_tready <= 1'b0;
         else rsp_tready <= ($urandom_range(0, 99) < 70);
      end
   end

   initial begin
      hold_rsp = 1'b0;
      @(posedge clock);
      wait (!reset);
      repeat (5000) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("longest_run_set_with_rollback: mismatch");
         $finish;
      end
   end

   initial begin
      board = new();
      board.clear_tables();
      cycle_count = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= KIND_INSERT;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, duplicates, ignored values, every kind.
      send_item(KIND_ROLLBACK, 13'd0, 1'b0);
      send_item(KIND_INSERT, 13'd1, 1'b0);
      send_item(KIND_INSERT, 13'd4096, 1'b0);
      send_item(KIND_INSERT, 13'd1, 1'b0);
      send_item(KIND_INSERT, 13'd0, 1'b0);
      send_item(KIND_INSERT, 13'd4097, 1'b0);
      send_item(KIND_INSERT, 13'h1FFF, 1'b0);
      send_item(KIND_INSERT, 13'd3, 1'b0);
      send_item(KIND_CHECKPOINT, 13'h1FFF, 1'b0);
      send_item(KIND_INSERT, 13'd2, 1'b0);
      send_item(KIND_INSERT, 13'd4095, 1'b0);
      send_item(KIND_INSERT, 13'd4, 1'b0);
      send_item(KIND_ROLLBACK, 13'd0, 1'b0);
      send_item(KIND_ROLLBACK, 13'd0, 1'b0);
      send_item(KIND_INSERT, 13'd2, 1'b0);
      send_item(KIND_INSERT, 13'd2730, 1'b0);
      send_item(KIND_INSERT, 13'd1365, 1'b0);
      send_item(KIND_CLEAR, 13'h1555, 1'b0);
      send_item(KIND_ROLLBACK, 13'd0, 1'b0);
      send_item(KIND_INSERT, 13'd2, 1'b0);
      send_item(KIND_CLEAR, 13'd0, 1'b0);

      send_random(2000);
      req_tvalid <= 1'b0;

      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0) begin
         $display("longest_run_set_with_rollback: match");
      end else begin
         $display("longest_run_set_with_rollback: mismatch");
      end
      $finish;
   end

endmodule
